### design/hgpw_pkg.sv
// Shared constants, row layouts and handshake structs for the point weld core.
// No dependencies; the core, the floor divider and the cell hash import this package.
`default_nettype none

package hgpw_pkg;

   localparam int MAX_POINTS = 4096;
   localparam int PT_IDX_W   = $clog2(MAX_POINTS);
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
   // Bucket select takes the low hash bits, so BUCKETS stays a power of two.
   localparam int BUCKETS    = 1024;
   localparam int BKT_W      = $clog2(BUCKETS);
   localparam int CELL_SCALE = 8;

   localparam int TOL_W      = 25;
   localparam int COORD_W    = 32;
   localparam int CELL_W     = 32;
   localparam int HASH_W     = 64;
   localparam int ONE_Q16    = 65536;
   localparam int SCALED_W   = TOL_W + $clog2(CELL_SCALE);
   localparam int UNIT_W     = $clog2(ONE_Q16) + 1;
   localparam int SIZE_W     = (SCALED_W > UNIT_W) ? SCALED_W : UNIT_W;

   localparam int DIV_STEPS  = COORD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [HASH_W-1:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [HASH_W-1:0] HASH_MUL1   = 64'hbf58476d1ce4e5b9;
   localparam logic [HASH_W-1:0] HASH_MUL2   = 64'h94d049bb133111eb;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_TOL_INDEX = '0;

   typedef struct packed {
      logic [COORD_W-1:0]  pos_x;
      logic [COORD_W-1:0]  pos_y;
      logic [COORD_W-1:0]  pos_z;
      logic [HASH_W-1:0]   cell_key;
      logic [PT_IDX_W-1:0] next;
   } point_row_type;

   typedef struct packed {
      logic                used;
      logic [PT_IDX_W-1:0] head;
      logic [PT_IDX_W-1:0] tail;
   } bucket_row_type;

   typedef struct packed {
      logic                     done;
      logic signed [CELL_W-1:0] quot;
      logic [SIZE_W-1:0]        rem;
   } div_rsp_type;

   typedef enum logic [2:0] {
      LVL_X = 3'b001,
      LVL_Y = 3'b010,
      LVL_Z = 3'b100
   } hash_level_type;

   typedef struct packed {
      logic           start;
      hash_level_type level;
   } hash_cmd_type;

endpackage

`default_nettype wire

### design/hash_grid_point_weld_core.sv
// Point weld core: floor dividers, cell hash, bucket and point RAMs, search sequencer.
// Uses hgpw_pkg, hgpw_ram, hgpw_floor_div and hgpw_cell_hash.
//
// Each accepted point is searched in the grid cells that its tolerance box
// touches (one to eight cells, x then y then z) and is matched, appended, or
// reported as store full. An item runs one at a time: accept, floor division,
// then per cell hash start and handoff plus a hash pass for each hash level
// that changes (all three for the first cell, z alone when only z steps), the
// bucket row read and a walk over the chain entries; an insert first reads
// and relinks the bucket tail when the bucket is in use, then writes the point
// and bucket rows, and the result register follows. The chain walk in the point
// RAM dominates for crowded buckets. After reset the bucket RAM is swept clear
// of all 1024 rows with req_ready low; register writes are taken during the
// sweep.
`default_nettype none

module hash_grid_point_weld_core import hgpw_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [COORD_W-1:0] req_pos_x,
   input  wire logic signed [COORD_W-1:0] req_pos_y,
   input  wire logic signed [COORD_W-1:0] req_pos_z,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [PT_IDX_W-1:0]            rsp_vertex_index,
   output logic                           rsp_created,
   output logic                           rsp_store_full,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_W-1:0]     paddr,
   input  wire logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]          prdata,
   output logic                           pready
);

   typedef enum logic [10:0] {
      ST_CLEAR   = 11'b00000000001,
      ST_IDLE    = 11'b00000000010,
      ST_DIV     = 11'b00000000100,
      ST_HASH    = 11'b00000001000,
      ST_BKT     = 11'b00000010000,
      ST_WALK    = 11'b00000100000,
      ST_LINK_RD = 11'b00001000000,
      ST_LINK_WR = 11'b00010000000,
      ST_INSERT  = 11'b00100000000,
      ST_RESULT  = 11'b01000000000,
      ST_SPARE   = 11'b10000000000
   } weld_state_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] base;
      logic                     span;
      logic                     qsel;
   } cell_span_type;

   function automatic cell_span_type axis_span(div_rsp_type d, logic [TOL_W-1:0] tol,
                                               logic [SIZE_W-1:0] size);
      logic          lo_bit;
      logic          hi_bit;
      cell_span_type s;
      lo_bit = d.rem < SIZE_W'(tol);
      hi_bit = ({1'b0, d.rem} + (SIZE_W+1)'(tol)) >= {1'b0, size};
      s.base = d.quot - {{(CELL_W-1){1'b0}}, lo_bit};
      s.span = lo_bit | hi_bit;
      s.qsel = lo_bit;
      return s;
   endfunction

   function automatic logic near(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                 logic [TOL_W-1:0] tol);
      logic signed [COORD_W+1:0] d;
      logic signed [COORD_W+1:0] t;
      d = $signed({{2{a[COORD_W-1]}}, a}) - $signed({{2{b[COORD_W-1]}}, b});
      t = $signed((COORD_W+2)'(tol));
      return (d <= t) && (d >= -t);
   endfunction

   weld_state_type            state_ff, state_in;
   logic [BKT_W-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [TOL_W-1:0]          tol_ff, tol_in;
   logic [SIZE_W-1:0]         size_ff, size_in;
   logic [COORD_W-1:0]        px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [CELL_W-1:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [CELL_W-1:0]  base_y_ff, base_y_in, base_z_ff, base_z_in;
   logic [2:0]                span_ff, span_in;
   logic [2:0]                qsel_ff, qsel_in;
   logic [2:0]                isel_ff, isel_in;
   logic [HASH_W-1:0]         cell_key_ff, cell_key_in;
   logic [HASH_W-1:0]         ins_key_ff, ins_key_in;
   logic                      is_q_ff, is_q_in;
   bucket_row_type            ins_row_ff, ins_row_in;
   logic [PT_IDX_W-1:0]       idx_ff, idx_in;
   logic [PT_IDX_W-1:0]       tail_ff, tail_in;
   logic [PT_IDX_W-1:0]       res_index_ff, res_index_in;
   logic                      res_created_ff, res_created_in;
   logic                      res_full_ff, res_full_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PT_IDX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic                      rsp_created_ff, rsp_created_in;
   logic                      rsp_full_ff, rsp_full_in;
   hash_cmd_type              hcmd_ff, hcmd_in;

   logic                      div_start;
   div_rsp_type               div_x, div_y, div_z;
   cell_span_type             sp_x, sp_y, sp_z;
   logic                      hash_done;
   logic [HASH_W-1:0]         hash_value;
   logic                      bkt_we;
   logic [BKT_W-1:0]          bkt_addr;
   bucket_row_type            bkt_wdata, bkt_rdata;
   logic                      pt_we;
   logic [PT_IDX_W-1:0]       pt_addr;
   point_row_type             pt_wdata, pt_rdata;
   logic                      adv;
   logic                      match;
   logic                      csr_write;
   logic [PT_IDX_W-1:0]       new_index;

   hgpw_floor_div u_div_x (
      .clock, .reset, .start(div_start), .dividend(req_pos_x), .divisor(size_in),
      .rsp(div_x)
   );
   hgpw_floor_div u_div_y (
      .clock, .reset, .start(div_start), .dividend(req_pos_y), .divisor(size_in),
      .rsp(div_y)
   );
   hgpw_floor_div u_div_z (
      .clock, .reset, .start(div_start), .dividend(req_pos_z), .divisor(size_in),
      .rsp(div_z)
   );

   hgpw_cell_hash u_hash (
      .clock, .reset, .cmd(hcmd_ff), .cell_x(cx_ff), .cell_y(cy_ff), .cell_z(cz_ff),
      .done(hash_done), .hash(hash_value)
   );

   hgpw_ram #(.WIDTH($bits(bucket_row_type)), .DEPTH(BUCKETS)) u_bucket_ram (
      .clock, .we(bkt_we), .addr(bkt_addr), .wdata(bkt_wdata), .rdata(bkt_rdata)
   );

   hgpw_ram #(.WIDTH($bits(point_row_type)), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock, .we(pt_we), .addr(pt_addr), .wdata(pt_wdata), .rdata(pt_rdata)
   );

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[CSR_ADDR_W-1:2] == CSR_TOL_INDEX)
                      ? CSR_DATA_W'(tol_ff) : '0;

   always_comb begin
      tol_in = tol_ff;
      if (csr_write && paddr[CSR_ADDR_W-1:2] == CSR_TOL_INDEX) begin
         tol_in = pwdata[TOL_W-1:0];
      end
   end

   assign sp_x      = axis_span(div_x, tol_ff, size_ff);
   assign sp_y      = axis_span(div_y, tol_ff, size_ff);
   assign sp_z      = axis_span(div_z, tol_ff, size_ff);
   assign new_index = count_ff[PT_IDX_W-1:0];
   assign match     = (pt_rdata.cell_key == cell_key_ff)
                      && near(pt_rdata.pos_x, px_ff, tol_ff)
                      && near(pt_rdata.pos_y, py_ff, tol_ff)
                      && near(pt_rdata.pos_z, pz_ff, tol_ff);

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      count_in       = count_ff;
      size_in        = size_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      pz_in          = pz_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      cz_in          = cz_ff;
      base_y_in      = base_y_ff;
      base_z_in      = base_z_ff;
      span_in        = span_ff;
      qsel_in        = qsel_ff;
      isel_in        = isel_ff;
      cell_key_in    = cell_key_ff;
      ins_key_in     = ins_key_ff;
      is_q_in        = is_q_ff;
      ins_row_in     = ins_row_ff;
      idx_in         = idx_ff;
      tail_in        = tail_ff;
      res_index_in   = res_index_ff;
      res_created_in = res_created_ff;
      res_full_in    = res_full_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_index_in   = rsp_index_ff;
      rsp_created_in = rsp_created_ff;
      rsp_full_in    = rsp_full_ff;
      hcmd_in        = '{start: 1'b0, level: LVL_X};
      div_start      = 1'b0;
      bkt_we         = 1'b0;
      bkt_addr       = '0;
      bkt_wdata      = '0;
      pt_we          = 1'b0;
      pt_addr        = '0;
      pt_wdata       = '0;
      req_ready      = 1'b0;
      adv            = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            bkt_we     = 1'b1;
            bkt_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            size_in   = (tol_ff == '0) ? SIZE_W'(ONE_Q16)
                                       : SIZE_W'(tol_ff) * SIZE_W'(CELL_SCALE);
            if (req_valid) begin
               px_in     = req_pos_x;
               py_in     = req_pos_y;
               pz_in     = req_pos_z;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_x.done) begin
               cx_in     = sp_x.base;
               cy_in     = sp_y.base;
               cz_in     = sp_z.base;
               base_y_in = sp_y.base;
               base_z_in = sp_z.base;
               span_in   = {sp_z.span, sp_y.span, sp_x.span};
               qsel_in   = {sp_z.qsel, sp_y.qsel, sp_x.qsel};
               isel_in   = '0;
               hcmd_in   = '{start: 1'b1, level: LVL_X};
               state_in  = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               cell_key_in = hash_value;
               is_q_in     = (isel_ff == qsel_ff);
               if (isel_ff == qsel_ff) begin
                  ins_key_in = hash_value;
               end
               bkt_addr = hash_value[BKT_W-1:0];
               state_in = ST_BKT;
            end
         end
         ST_BKT: begin
            // the home cell's row is kept for the insert; nothing writes during search
            if (is_q_ff) begin
               ins_row_in = bkt_rdata;
            end
            if (!bkt_rdata.used) begin
               adv = 1'b1;
            end else begin
               idx_in   = bkt_rdata.head;
               tail_in  = bkt_rdata.tail;
               pt_addr  = bkt_rdata.head;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (match) begin
               res_index_in   = idx_ff;
               res_created_in = 1'b0;
               res_full_in    = 1'b0;
               state_in       = ST_RESULT;
            end else if (idx_ff == tail_ff) begin
               adv = 1'b1;
            end else begin
               idx_in  = pt_rdata.next;
               pt_addr = pt_rdata.next;
            end
         end
         ST_LINK_RD: begin
            pt_addr  = ins_row_ff.tail;
            state_in = ST_LINK_WR;
         end
         ST_LINK_WR: begin
            pt_we         = 1'b1;
            pt_addr       = ins_row_ff.tail;
            pt_wdata      = pt_rdata;
            pt_wdata.next = new_index;
            state_in      = ST_INSERT;
         end
         ST_INSERT: begin
            pt_we          = 1'b1;
            pt_addr        = new_index;
            pt_wdata       = '{pos_x: px_ff, pos_y: py_ff, pos_z: pz_ff,
                               cell_key: ins_key_ff, next: '0};
            bkt_we         = 1'b1;
            bkt_addr       = ins_key_ff[BKT_W-1:0];
            bkt_wdata.used = 1'b1;
            bkt_wdata.head = ins_row_ff.used ? ins_row_ff.head : new_index;
            bkt_wdata.tail = new_index;
            count_in       = count_ff + 1'b1;
            res_index_in   = new_index;
            res_created_in = 1'b1;
            res_full_in    = 1'b0;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_index_in   = res_index_ff;
               rsp_created_in = res_created_ff;
               rsp_full_in    = res_full_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step to the next cell in x, y, z order; rehash only the levels that change
      if (adv) begin
         if (!isel_ff[2] && span_ff[2]) begin
            isel_in[2] = 1'b1;
            cz_in      = cz_ff + CELL_W'(1);
            hcmd_in    = '{start: 1'b1, level: LVL_Z};
            state_in   = ST_HASH;
         end else if (!isel_ff[1] && span_ff[1]) begin
            isel_in[2:1] = 2'b01;
            cy_in        = cy_ff + CELL_W'(1);
            cz_in        = base_z_ff;
            hcmd_in      = '{start: 1'b1, level: LVL_Y};
            state_in     = ST_HASH;
         end else if (!isel_ff[0] && span_ff[0]) begin
            isel_in  = 3'b001;
            cx_in    = cx_ff + CELL_W'(1);
            cy_in    = base_y_ff;
            cz_in    = base_z_ff;
            hcmd_in  = '{start: 1'b1, level: LVL_X};
            state_in = ST_HASH;
         end else if (count_ff == COUNT_W'(MAX_POINTS)) begin
            res_index_in   = '0;
            res_created_in = 1'b0;
            res_full_in    = 1'b1;
            state_in       = ST_RESULT;
         end else if (ins_row_in.used) begin
            state_in = ST_LINK_RD;
         end else begin
            state_in = ST_INSERT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         count_ff     <= '0;
         tol_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hcmd_ff      <= '{start: 1'b0, level: LVL_X};
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         count_ff     <= count_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
         hcmd_ff      <= hcmd_in;
      end
      size_ff        <= size_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      pz_ff          <= pz_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      cz_ff          <= cz_in;
      base_y_ff      <= base_y_in;
      base_z_ff      <= base_z_in;
      span_ff        <= span_in;
      qsel_ff        <= qsel_in;
      isel_ff        <= isel_in;
      cell_key_ff    <= cell_key_in;
      ins_key_ff     <= ins_key_in;
      is_q_ff        <= is_q_in;
      ins_row_ff     <= ins_row_in;
      idx_ff         <= idx_in;
      tail_ff        <= tail_in;
      res_index_ff   <= res_index_in;
      res_created_ff <= res_created_in;
      res_full_ff    <= res_full_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_created_ff <= rsp_created_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_created      = rsp_created_ff;
   assign rsp_store_full   = rsp_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_created_ff && rsp_full_ff))
      else $error("result both created and full");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance point count");

   a_full_only_at_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_full_ff |-> count_ff == COUNT_W'(MAX_POINTS))
      else $error("store full reported below capacity");

endmodule

`default_nettype wire

### design/hgpw_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Standalone; holds the point table and the bucket table.
`default_nettype none

module hgpw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### design/hgpw_floor_div.sv
// Bit-serial floor division of a signed coordinate by the cell size.
// Uses hgpw_pkg; returns quotient and non-negative remainder.
`default_nettype none

module hgpw_floor_div import hgpw_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [COORD_W-1:0] dividend,
   input  wire logic [SIZE_W-1:0]         divisor,
   output div_rsp_type                    rsp
);

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_RUN  = 3'b010,
      DV_FIX  = 3'b100
   } div_state_type;

   div_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [COORD_W-1:0]   quo_ff, quo_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [SIZE_W-1:0]    dsr_ff, dsr_in;
   logic                 neg_ff, neg_in;
   div_rsp_type          rsp_ff, rsp_in;
   logic [SIZE_W:0]      trial;
   logic [SIZE_W:0]      diff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      neg_in   = neg_ff;
      rsp_in   = rsp_ff;
      rsp_in.done = 1'b0;
      trial    = {rem_ff, quo_ff[COORD_W-1]};
      diff     = trial - {1'b0, dsr_ff};
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               neg_in   = dividend[COORD_W-1];
               quo_in   = dividend[COORD_W-1] ? (~dividend + 1'b1) : dividend;
               rem_in   = '0;
               dsr_in   = divisor;
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            // restoring step: one quotient bit per cycle
            if (trial >= {1'b0, dsr_ff}) begin
               rem_in = diff[SIZE_W-1:0];
               quo_in = {quo_ff[COORD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[SIZE_W-1:0];
               quo_in = {quo_ff[COORD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = DV_FIX;
            end
         end
         DV_FIX: begin
            // round toward minus infinity for negative dividends
            rsp_in.done = 1'b1;
            if (!neg_ff) begin
               rsp_in.quot = quo_ff;
               rsp_in.rem  = rem_ff;
            end else if (rem_ff != '0) begin
               rsp_in.quot = ~quo_ff;
               rsp_in.rem  = dsr_ff - rem_ff;
            end else begin
               rsp_in.quot = ~quo_ff + 1'b1;
               rsp_in.rem  = '0;
            end
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= DV_IDLE;
         rsp_ff.done <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rsp_ff.done <= rsp_in.done;
      end
      cnt_ff      <= cnt_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      neg_ff      <= neg_in;
      rsp_ff.quot <= rsp_in.quot;
      rsp_ff.rem  <= rsp_in.rem;
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

### design/hgpw_cell_hash.sv
// Sequential 64-bit cell hash over three cell coordinates, one 32x32 multiplier.
// Uses hgpw_pkg; keeps the x and x,y prefix hashes so a search can resume mid-way.
`default_nettype none

module hgpw_cell_hash import hgpw_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire hash_cmd_type             cmd,
   input  wire logic signed [CELL_W-1:0] cell_x,
   input  wire logic signed [CELL_W-1:0] cell_y,
   input  wire logic signed [CELL_W-1:0] cell_z,
   output logic                          done,
   output logic [HASH_W-1:0]             hash
);

   typedef enum logic [10:0] {
      PH_IDLE = 11'b00000000001,
      PH_ADD  = 11'b00000000010,
      PH_XS30 = 11'b00000000100,
      PH_M1LL = 11'b00000001000,
      PH_M1HL = 11'b00000010000,
      PH_M1LH = 11'b00000100000,
      PH_XS27 = 11'b00001000000,
      PH_M2LL = 11'b00010000000,
      PH_M2HL = 11'b00100000000,
      PH_M2LH = 11'b01000000000,
      PH_XS31 = 11'b10000000000
   } hash_phase_type;

   hash_phase_type     phase_ff, phase_in;
   hash_level_type     level_ff, level_in;
   logic [HASH_W-1:0]  h_ff, h_in;
   logic [HASH_W-1:0]  h1_ff, h1_in;
   logic [HASH_W-1:0]  h2_ff, h2_in;
   logic [HASH_W-1:0]  x_ff, x_in;
   logic [HASH_W-1:0]  acc_ff, acc_in;
   logic               done_ff, done_in;
   logic [CELL_W-1:0]  axis;
   logic [HASH_W-1:0]  axis_ext;
   logic [31:0]        mul_a;
   logic [31:0]        mul_b;
   logic [63:0]        prod;
   logic [HASH_W-1:0]  h_mix;

   always_comb begin
      case (level_ff)
         LVL_X:   axis = cell_x;
         LVL_Y:   axis = cell_y;
         LVL_Z:   axis = cell_z;
         default: axis = cell_x;
      endcase
      axis_ext = {{(HASH_W-CELL_W){axis[CELL_W-1]}}, axis};
   end

   // one partial product a cycle; only the low 64 bits of the full product matter
   always_comb begin
      case (phase_ff)
         PH_M1LL: begin mul_a = x_ff[31:0];  mul_b = HASH_MUL1[31:0];  end
         PH_M1HL: begin mul_a = x_ff[63:32]; mul_b = HASH_MUL1[31:0];  end
         PH_M1LH: begin mul_a = x_ff[31:0];  mul_b = HASH_MUL1[63:32]; end
         PH_M2LL: begin mul_a = x_ff[31:0];  mul_b = HASH_MUL2[31:0];  end
         PH_M2HL: begin mul_a = x_ff[63:32]; mul_b = HASH_MUL2[31:0];  end
         PH_M2LH: begin mul_a = x_ff[31:0];  mul_b = HASH_MUL2[63:32]; end
         default: begin mul_a = '0;          mul_b = '0;               end
      endcase
      prod  = mul_a * mul_b;
      h_mix = acc_ff ^ (acc_ff >> 31);
   end

   always_comb begin
      phase_in = phase_ff;
      level_in = level_ff;
      h_in     = h_ff;
      h1_in    = h1_ff;
      h2_in    = h2_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               level_in = cmd.level;
               case (cmd.level)
                  LVL_Y:   h_in = h1_ff;
                  LVL_Z:   h_in = h2_ff;
                  default: h_in = '0;
               endcase
               phase_in = PH_ADD;
            end
         end
         PH_ADD: begin
            x_in     = h_ff ^ (axis_ext + HASH_GOLDEN + (h_ff << 6) + (h_ff >> 2));
            phase_in = PH_XS30;
         end
         PH_XS30: begin
            x_in     = x_ff ^ (x_ff >> 30);
            phase_in = PH_M1LL;
         end
         PH_M1LL: begin
            acc_in   = prod;
            phase_in = PH_M1HL;
         end
         PH_M1HL: begin
            acc_in   = acc_ff + {prod[31:0], 32'b0};
            phase_in = PH_M1LH;
         end
         PH_M1LH: begin
            acc_in   = acc_ff + {prod[31:0], 32'b0};
            phase_in = PH_XS27;
         end
         PH_XS27: begin
            x_in     = acc_ff ^ (acc_ff >> 27);
            phase_in = PH_M2LL;
         end
         PH_M2LL: begin
            acc_in   = prod;
            phase_in = PH_M2HL;
         end
         PH_M2HL: begin
            acc_in   = acc_ff + {prod[31:0], 32'b0};
            phase_in = PH_M2LH;
         end
         PH_M2LH: begin
            acc_in   = acc_ff + {prod[31:0], 32'b0};
            phase_in = PH_XS31;
         end
         PH_XS31: begin
            h_in = h_mix;
            case (level_ff)
               LVL_X: begin
                  h1_in    = h_mix;
                  level_in = LVL_Y;
                  phase_in = PH_ADD;
               end
               LVL_Y: begin
                  h2_in    = h_mix;
                  level_in = LVL_Z;
                  phase_in = PH_ADD;
               end
               default: begin
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end
            endcase
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         level_ff <= LVL_X;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         done_ff  <= done_in;
      end
      h_ff   <= h_in;
      h1_ff  <= h1_in;
      h2_ff  <= h2_in;
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign hash = h_ff;

endmodule

`default_nettype wire

### sim/hash_grid_point_weld_core_tb.sv
// Self-checking testbench for the point weld core: points in over valid/ready, indexes out.
// Depends on hgpw_pkg and hash_grid_point_weld_core; keeps its own weld-store model.
`default_nettype none

module hash_grid_point_weld_core_tb;
   import hgpw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [COORD_W-1:0] x, y, z;
   } point_type;

   typedef struct {
      logic [PT_IDX_W-1:0] vertex_index;
      logic                created;
      logic                store_full;
   } weld_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PT_IDX_W-1:0] rsp_vertex_index;
   logic rsp_created, rsp_store_full;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   hash_grid_point_weld_core dut (.*);

   // Weld store model
   logic [TOL_W-1:0]          weld_tol = '0;
   logic signed [COORD_W-1:0] pt_x [MAX_POINTS];
   logic signed [COORD_W-1:0] pt_y [MAX_POINTS];
   logic signed [COORD_W-1:0] pt_z [MAX_POINTS];
   logic [HASH_W-1:0]         pt_key [MAX_POINTS];
   int unsigned               pt_next [MAX_POINTS];
   int unsigned               bkt_head [BUCKETS];
   int unsigned               bkt_tail [BUCKETS];
   bit                        bkt_used [BUCKETS];
   int unsigned               stored_count = 0;

   point_type       pending_points[$];
   point_type       sent_points[$];
   weld_result_type expected_welds[$];
   int              errors = 0;
   int              sender_idle_pct = 14;
   int              receiver_idle_pct = 80;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint floor_q(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic logic [63:0] mix_axis(logic [63:0] h, longint axis);
      h ^= 64'(axis) + HASH_GOLDEN + (h << 6) + (h >> 2);
      h = (h ^ (h >> 30)) * HASH_MUL1;
      h = (h ^ (h >> 27)) * HASH_MUL2;
      h ^= h >> 31;
      return h;
   endfunction

   function automatic logic [63:0] cell_key(longint cx, longint cy, longint cz);
      return mix_axis(mix_axis(mix_axis(64'd0, cx), cy), cz);
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   // Walk one bucket chain; return the first point of this cell within tolerance, or -1.
   function automatic int find_in_cell(logic [63:0] h, longint px, longint py, longint pz,
                                       longint tol);
      int unsigned b, idx;
      b = h % BUCKETS;
      if (!bkt_used[b]) return -1;
      idx = bkt_head[b];
      for (int unsigned s = 0; s < stored_count; s++) begin
         if (pt_key[idx] == h && abs64(longint'(pt_x[idx]) - px) <= tol &&
             abs64(longint'(pt_y[idx]) - py) <= tol &&
             abs64(longint'(pt_z[idx]) - pz) <= tol)
            return idx;
         if (idx == bkt_tail[b]) return -1;
         idx = pt_next[idx];
      end
      return -1;
   endfunction

   function automatic weld_result_type weld_point(point_type p);
      weld_result_type r;
      longint tol, cell_size, px, py, pz;
      int found;
      logic [63:0] h;
      int unsigned b, v;
      tol = longint'(weld_tol);
      cell_size = tol > 0 ? tol * CELL_SCALE : ONE_Q16;
      px = p.x; py = p.y; pz = p.z;
      found = -1;
      for (longint cx = floor_q(px - tol, cell_size);
           cx <= floor_q(px + tol, cell_size) && found < 0; cx++)
         for (longint cy = floor_q(py - tol, cell_size);
              cy <= floor_q(py + tol, cell_size) && found < 0; cy++)
            for (longint cz = floor_q(pz - tol, cell_size);
                 cz <= floor_q(pz + tol, cell_size) && found < 0; cz++)
               found = find_in_cell(cell_key(cx, cy, cz), px, py, pz, tol);
      if (found >= 0) begin
         r.vertex_index = found[PT_IDX_W-1:0];
         r.created = 1'b0;
         r.store_full = 1'b0;
      end else if (stored_count >= MAX_POINTS) begin
         r.vertex_index = '0;
         r.created = 1'b0;
         r.store_full = 1'b1;
      end else begin
         v = stored_count;
         h = cell_key(floor_q(px, cell_size), floor_q(py, cell_size),
                      floor_q(pz, cell_size));
         b = h % BUCKETS;
         pt_x[v] = p.x; pt_y[v] = p.y; pt_z[v] = p.z;
         pt_key[v] = h;
         if (bkt_used[b]) pt_next[bkt_tail[b]] = v;
         else begin
            bkt_used[b] = 1'b1;
            bkt_head[b] = v;
         end
         bkt_tail[b] = v;
         stored_count = v + 1;
         r.vertex_index = v[PT_IDX_W-1:0];
         r.created = 1'b1;
         r.store_full = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Driver: predict on each transfer, then load the next point or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            expected_welds.insert(expected_welds.size(),
                                  weld_point('{req_pos_x, req_pos_y, req_pos_z}));
         if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            point_type p;
            p = pending_points.pop_front();
            req_pos_x <= p.x;
            req_pos_y <= p.y;
            req_pos_z <= p.z;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_welds.size() == 0) begin
               report_mismatch("outstanding results", 0, 1);
            end else begin
               weld_result_type e;
               e = expected_welds.pop_front();
               if (rsp_vertex_index !== e.vertex_index)
                  report_mismatch("vertex_index", rsp_vertex_index, e.vertex_index);
               if (rsp_created !== e.created)
                  report_mismatch("created", rsp_created, e.created);
               if (rsp_store_full !== e.store_full)
                  report_mismatch("store_full", rsp_store_full, e.store_full);
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic csr_write(logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({CSR_TOL_INDEX, 2'b00}); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      weld_tol = value[TOL_W-1:0];
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      readback = prdata;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0;
      if (readback !== CSR_DATA_W'(weld_tol))
         report_mismatch("weld_tolerance readback", readback, weld_tol);
   endtask

   task automatic push_point(logic signed [31:0] x, y, z);
      point_type p;
      p = '{x, y, z};
      pending_points.insert(pending_points.size(), p);
      sent_points.insert(sent_points.size(), p);
   endtask

   task automatic drain();
      while (pending_points.size() != 0 || req_valid || expected_welds.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Mostly points clustered around a few centers, some repeats, some noise.
   task automatic push_clustered(int count, longint spread);
      logic signed [31:0] centers [6];
      longint off;
      logic signed [31:0] c [3];
      centers = '{32'sh7FFF_FFF0, 32'sh8000_0010, 32'sd0, -32'sd65536,
                  $urandom, $urandom};
      for (int i = 0; i < count; i++) begin
         int roll;
         roll = $urandom_range(99);
         if (roll < 20) begin
            point_type p;
            p = sent_points[$urandom_range(sent_points.size() - 1)];
            push_point(p.x, p.y, p.z);
         end else if (roll < 30) begin
            push_point($urandom, $urandom, $urandom);
         end else begin
            for (int k = 0; k < 3; k++) begin
               off = longint'($urandom_range(32'(4 * spread))) - 2 * spread;
               c[k] = 32'(longint'(centers[$urandom_range(5)]) + off);
            end
            push_point(c[0], c[1], c[2]);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // exact-match mode: extremes, duplicates, off-by-one neighbors, negative floors
      csr_write(32'd0);
      push_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      push_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      push_point(32'sd0, 32'sd0, 32'sd0);
      push_point(32'sd0, 32'sd0, 32'sd0);
      push_point(32'sd1, 32'sd0, 32'sd0);
      push_point(-32'sd1, 32'sd0, 32'sd0);
      push_point(-32'sd1, 32'sd0, 32'sd0);
      push_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      push_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd65536);
      push_point(-32'sd65536, -32'sd65537, 32'sd65535);
      push_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      push_point(32'sd65536, 32'sd0, 32'sd0);
      drain();

      // small tolerance: inclusive edge and one past it
      csr_write(32'd1000);
      push_point(32'sd500000, 32'sd500000, 32'sd500000);
      push_point(32'sd501000, 32'sd499000, 32'sd501000);
      push_point(32'sd501001, 32'sd500000, 32'sd500000);
      push_point(32'sd0, 32'sd1000, -32'sd1000);
      push_point(-32'sd7999, 32'sd7999, 32'sd8000);
      push_clustered(200, 1000);
      drain();

      // large tolerance of 2^24; points stored earlier keep their old cells
      csr_write(32'd16777216);
      push_clustered(200, 16777216);
      drain();

      sender_idle_pct = 80;
      receiver_idle_pct = 14;
      // all ones: register keeps the low bits only
      csr_write(32'hFFFF_FFFF);
      push_clustered(200, 32'h1FF_FFFF);
      drain();

      csr_write(32'd3);
      push_clustered(200, 3);
      drain();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      csr_write(32'h0003_0000);
      push_clustered(200, 32'h3_0000);
      drain();

      // random scatter in exact-match mode, then repeats of earlier points
      csr_write(32'd0);
      for (int i = 0; i < 180; i++) push_point($urandom, $urandom, $urandom);
      for (int i = 0; i < 10; i++) begin
         point_type p;
         p = sent_points[$urandom_range(sent_points.size() - 1)];
         push_point(p.x, p.y, p.z);
      end
      drain();
      repeat (200) @(posedge clock);

      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #40ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
